// File: design/bam_pkg.sv
// Package for the bottleneck assignment matcher: sizes, constants, sequencer codes.
// No dependencies; used by the top level of the block.
`default_nettype none
package bam_pkg;
  localparam int unsigned MaxSide   = 64;
  localparam int unsigned CostBits  = 30;
  localparam int unsigned IdxW      = $clog2(MaxSide + 1);
  localparam int unsigned QAddrW    = $clog2(MaxSide);
  localparam int unsigned TblDepth  = MaxSide + 1;
  localparam int unsigned AddrW     = $clog2(MaxSide * MaxSide);
  localparam int unsigned CntW      = $clog2(MaxSide * MaxSide + 1);
  localparam logic [CostBits-1:0] SearchLimit = CostBits'(1000000000);
  localparam logic [IdxW-1:0] SizeReset = IdxW'(MaxSide);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CostBits-1:0] cost_t;

  typedef enum logic [14:0] {
    ST_LOAD   = 15'b000000000000001,
    ST_PROBE  = 15'b000000000000010,
    ST_CLEAR  = 15'b000000000000100,
    ST_INITRQ = 15'b000000000001000,
    ST_INIT   = 15'b000000000010000,
    ST_POP    = 15'b000000000100000,
    ST_POPW   = 15'b000000001000000,
    ST_SCANRQ = 15'b000000010000000,
    ST_SCANW  = 15'b000000100000000,
    ST_SCAN   = 15'b000001000000000,
    ST_AUG    = 15'b000010000000000,
    ST_AUGX   = 15'b000100000000000,
    ST_AUGN   = 15'b001000000000000,
    ST_DONEP  = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } state_e;
endpackage
`default_nettype wire

// File: design/bam_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module bam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/bottleneck_assignment_matcher_core.sv
// Top level of the bottleneck assignment matcher: APB size register, cost RAM, table RAMs
// and the sequencer that runs the binary search and BFS matching. Uses bam_pkg, bam_ram.
// Loading: one cost transaction per cycle. After the last entry the block drops
// cost_ready_o for the whole search of 29 or 30 probes. A probe clears the matching; each
// BFS round seeds the queue with free workers, pops workers, examines each edge in
// request, wait and scan states (the cost and table RAMs have registered reads) and flips
// the path step by step. The result sits in an output register until accepted. Reset,
// asynchronous and active low, clears all control state and sets the size register to 64.
`default_nettype none
module bottleneck_assignment_matcher_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic cost_valid_i,
  output logic cost_ready_o,
  input  wire logic [bam_pkg::CostBits-1:0] cost_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [bam_pkg::CostBits-1:0] bottleneck_o,
  output logic found_o
);
  import bam_pkg::*;

  state_e state_q;
  logic [6:0] size_q;
  idx_t n;
  logic [CntW-1:0] load_q;
  logic [CntW-1:0] total;
  cost_t lo_q, hi_q, best_q, mid_q;
  idx_t head_q, tail_q, x_q, j_q, cnt_q, i_q, w_q;
  logic cost_ok_q;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] row_base_q;
  cost_t rdata;
  logic wr;
  logic do_load;
  logic scan_take;

  // Per-index tables, each in its own RAM: job_of_worker, worker_of_job,
  // path predecessor, queued mark and the BFS queue.
  logic jw_we, wj_we, pred_we, mark_we, q_we;
  idx_t jw_waddr, jw_wdata, jw_raddr, jw_rdata;
  idx_t wj_waddr, wj_wdata, wj_rdata;
  idx_t pred_waddr, pred_wdata, pred_rdata;
  idx_t mark_waddr;
  logic mark_wdata, mark_rdata;
  idx_t q_wdata, q_rdata;

  // The size register: zero acts as one, large values clip to MaxSide.
  always_comb begin
    if (size_q == 7'd0) n = IdxW'(1);
    else if ({1'b0, size_q} > 8'(MaxSide)) n = IdxW'(MaxSide);
    else n = IdxW'(size_q);
  end
  assign total = CntW'(n) * CntW'(n);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, size_q} : 32'd0;
  assign wr = psel && penable && pwrite && (paddr == 2'd0);
  assign cost_ready_o = (state_q == ST_LOAD);
  assign do_load = cost_valid_i && cost_ready_o;

  bam_ram #(.Width(CostBits), .Depth(MaxSide * MaxSide)) u_cost (
    .clk_i, .we_i(do_load && (load_q < total)), .waddr_i(load_q[AddrW-1:0]),
    .wdata_i(cost_i), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Edge (x, j) lives at (x-1)*n + (j-1); the row base is kept as a register.
  assign raddr = row_base_q + AddrW'(j_q - IdxW'(1));

  // A scanned edge is taken when it is cheap enough and its job is free or
  // held by a worker not yet queued.
  assign scan_take = cost_ok_q && (w_q == '0 || !mark_rdata);

  bam_ram #(.Width(IdxW), .Depth(TblDepth)) u_jw (
    .clk_i, .we_i(jw_we), .waddr_i(jw_waddr), .wdata_i(jw_wdata),
    .raddr_i(jw_raddr), .rdata_o(jw_rdata)
  );
  bam_ram #(.Width(IdxW), .Depth(TblDepth)) u_wj (
    .clk_i, .we_i(wj_we), .waddr_i(wj_waddr), .wdata_i(wj_wdata),
    .raddr_i(j_q), .rdata_o(wj_rdata)
  );
  bam_ram #(.Width(IdxW), .Depth(TblDepth)) u_pred (
    .clk_i, .we_i(pred_we), .waddr_i(pred_waddr), .wdata_i(pred_wdata),
    .raddr_i(j_q), .rdata_o(pred_rdata)
  );
  // The mark of the worker that holds job j is looked up from the worker_of_job
  // read data, so it arrives in the cycle after that read data.
  bam_ram #(.Width(1), .Depth(TblDepth)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(wj_rdata), .rdata_o(mark_rdata)
  );
  bam_ram #(.Width(IdxW), .Depth(MaxSide)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(tail_q[QAddrW-1:0]), .wdata_i(q_wdata),
    .raddr_i(head_q[QAddrW-1:0]), .rdata_o(q_rdata)
  );

  // Table write ports and the job_of_worker read address, by sequencer state.
  always_comb begin
    jw_we = 1'b0; jw_waddr = i_q; jw_wdata = '0; jw_raddr = i_q;
    wj_we = 1'b0; wj_waddr = i_q; wj_wdata = '0;
    pred_we = 1'b0; pred_waddr = i_q; pred_wdata = '0;
    mark_we = 1'b0; mark_waddr = i_q; mark_wdata = 1'b0;
    q_we = 1'b0; q_wdata = i_q;
    case (state_q)
      ST_CLEAR: begin
        jw_we = 1'b1;
        wj_we = 1'b1;
      end
      ST_INIT: begin
        // Clear the predecessor, and mark and enqueue the worker if it is free.
        pred_we = 1'b1;
        mark_we = 1'b1;
        mark_wdata = (jw_rdata == '0);
        q_we = (jw_rdata == '0);
      end
      ST_SCAN: begin
        if (scan_take) begin
          pred_we = 1'b1; pred_waddr = j_q; pred_wdata = x_q;
          if (w_q != '0) begin
            mark_we = 1'b1; mark_waddr = w_q; mark_wdata = 1'b1;
            q_we = (tail_q < IdxW'(MaxSide)); q_wdata = w_q;
          end
        end
      end
      ST_AUGX: begin
        // Flip one path edge; the same-cycle read returns the worker's old job.
        jw_we = 1'b1; jw_waddr = pred_rdata; jw_wdata = j_q; jw_raddr = pred_rdata;
        wj_we = 1'b1; wj_waddr = j_q; wj_wdata = pred_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      size_q <= 7'(SizeReset);
      load_q <= '0;
      out_valid_o <= 1'b0;
      bottleneck_o <= '0;
      found_o <= 1'b0;
      lo_q <= CostBits'(1);
      hi_q <= SearchLimit;
      best_q <= '0;
      mid_q <= '0;
      row_base_q <= '0;
      head_q <= '0; tail_q <= '0; cnt_q <= '0; i_q <= '0;
      x_q <= '0; j_q <= '0; w_q <= '0; cost_ok_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_o || out_ready_i)) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (wr) begin
        size_q <= pwdata[6:0];
        load_q <= '0;
      end
      case (state_q)
        ST_LOAD: if (do_load && !wr) begin
          if (load_q + CntW'(1) >= total) begin
            load_q <= '0;
            lo_q <= CostBits'(1);
            hi_q <= SearchLimit;
            best_q <= '0;
            state_q <= ST_PROBE;
          end else load_q <= load_q + CntW'(1);
        end
        ST_PROBE: begin
          if (lo_q > hi_q) state_q <= ST_OUT;
          else begin
            mid_q <= CostBits'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
            i_q <= '0; cnt_q <= '0;
            state_q <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (i_q == n) begin
            state_q <= ST_INITRQ; i_q <= IdxW'(1); tail_q <= '0; head_q <= '0;
          end else i_q <= i_q + IdxW'(1);
        end
        ST_INITRQ: state_q <= ST_INIT;   // job_of_worker read in flight
        ST_INIT: begin
          if (jw_rdata == '0) tail_q <= tail_q + IdxW'(1);
          if (i_q == n) state_q <= ST_POP;
          else begin
            i_q <= i_q + IdxW'(1);
            state_q <= ST_INITRQ;
          end
        end
        ST_POP: begin
          if (head_q < tail_q && head_q < IdxW'(MaxSide)) state_q <= ST_POPW;
          else state_q <= ST_DONEP;
        end
        ST_POPW: begin
          x_q <= q_rdata;
          row_base_q <= AddrW'((CntW'(q_rdata) - CntW'(1)) * CntW'(n));
          head_q <= head_q + IdxW'(1);
          j_q <= IdxW'(1);
          state_q <= ST_SCANRQ;
        end
        ST_SCANRQ: state_q <= ST_SCANW;   // cost and worker_of_job reads in flight
        ST_SCANW: begin
          cost_ok_q <= (rdata <= mid_q);
          w_q <= wj_rdata;
          state_q <= ST_SCAN;             // mark read in flight
        end
        ST_SCAN: begin
          if (scan_take && w_q != '0 && tail_q < IdxW'(MaxSide)) tail_q <= tail_q + IdxW'(1);
          if (scan_take && w_q == '0) state_q <= ST_AUG;
          else if (j_q == n) state_q <= ST_POP;
          else begin
            j_q <= j_q + IdxW'(1);
            state_q <= ST_SCANRQ;
          end
          i_q <= '0;
        end
        ST_AUG: begin
          // One step of the path flip per pass through AUG, AUGX and AUGN.
          if (j_q == '0 || i_q > IdxW'(MaxSide)) begin
            cnt_q <= cnt_q + IdxW'(1);
            if (cnt_q + IdxW'(1) >= n) state_q <= ST_DONEP;
            else begin
              i_q <= IdxW'(1); tail_q <= '0; head_q <= '0; state_q <= ST_INITRQ;
            end
          end else state_q <= ST_AUGX;
        end
        ST_AUGX: state_q <= ST_AUGN;
        ST_AUGN: begin
          j_q <= jw_rdata;
          i_q <= i_q + IdxW'(1);
          state_q <= ST_AUG;
        end
        ST_DONEP: begin
          if (cnt_q == n) begin
            best_q <= mid_q; hi_q <= mid_q - CostBits'(1);
          end else lo_q <= mid_q + CostBits'(1);
          state_q <= ST_PROBE;
        end
        ST_OUT: if (!out_valid_o || out_ready_i) begin
          bottleneck_o <= best_q;
          found_o <= (best_q != '0);
          state_q <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bottleneck_o)) else $error("out");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o == (bottleneck_o != '0))) else $error("found");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_LOAD |-> !cost_ready_o) else $error("ready");
endmodule
`default_nettype wire
